>>> design/lkvc_pkg.sv
// lkvc_pkg: shared types and constants for the LRU key/value cache.
// Request and response payload structs, operation codes, fixed field widths.
// No dependencies.
package lkvc_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0]          CAP_RESET  = 5'd16;
    localparam logic signed [VALUE_W-1:0] VALUE_MISS = -32'sd1;
    localparam logic signed [VALUE_W-1:0] VALUE_PUT  = 32'sd0;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic signed [KEY_W-1:0]    key;
        logic signed [VALUE_W-1:0]  value;
    } t_req;

    typedef struct packed {
        logic                       found;
        logic signed [VALUE_W-1:0]  value_out;
        logic                       evicted;
    } t_rsp;

endpackage

>>> design/lru_key_value_cache.sv
// lru_key_value_cache: fully associative key/value store with LRU replacement.
// Depends on lkvc_pkg (payload structs, op codes, widths).
//
// Usage:
//   Request channel (i_req_valid / o_req_ready / i_req) carries a get or a put.
//   Response channel (o_rsp_valid / i_rsp_ready / o_rsp) returns one response
//   per request, in order: found flag, value (hit value, -1 on get miss, 0 on
//   put) and an evicted flag for a put that pushed out the least recent entry.
//   i_cfg_we / i_cfg_wdata write the capacity register (0 reads as 1, values
//   above MAX_ENTRIES read as MAX_ENTRIES); any write empties the store. Write
//   it only while no transaction is in flight.
// Pipeline: a request goes into the request register, then through lookup/update
//   into the response register, which drives o_rsp_valid and o_rsp.
// Throughput: one transaction per cycle while responses are taken. All
//   MAX_ENTRIES key compares and the rank update run in parallel in the lookup
//   stage, so each access sees the store as the previous access left it.
// Reset: valid bits, fill count and ranks clear; capacity returns to 16.
// Stall: the response register holds until taken; the request register then
//   fills and o_req_ready drops until the response side moves again.
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    output logic                      o_req_ready,
    input  lkvc_pkg::t_req            i_req,
    output logic                      o_rsp_valid,
    input  logic                      i_rsp_ready,
    output lkvc_pkg::t_rsp            o_rsp,
    input  logic                      i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0] i_cfg_wdata
);

    localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (FILL_W > lkvc_pkg::CAP_W) ? FILL_W : lkvc_pkg::CAP_W;

    // store
    logic signed [lkvc_pkg::KEY_W-1:0]   r_key   [MAX_ENTRIES];
    logic signed [lkvc_pkg::VALUE_W-1:0] r_value [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]              r_valid, n_valid;
    logic [RANK_W-1:0]                   r_rank  [MAX_ENTRIES];
    logic [RANK_W-1:0]                   n_rank  [MAX_ENTRIES];
    logic [FILL_W-1:0]                   r_fill, n_fill;
    logic [lkvc_pkg::CAP_W-1:0]          r_capacity;

    // pipeline
    lkvc_pkg::t_req r_req;
    logic           r_req_valid;
    lkvc_pkg::t_rsp r_rsp, n_rsp;
    logic           r_rsp_valid;
    logic           fire;

    // lookup stage
    logic [MAX_ENTRIES-1:0]              hit_oh, victim_oh, slot_oh;
    logic [MAX_ENTRIES-1:0]              key_wr;
    logic                                hit;
    logic [RANK_W-1:0]                   hit_rank;
    logic signed [lkvc_pkg::VALUE_W-1:0] hit_value;
    logic [CMP_W-1:0]                    cap_eff;
    logic                                full;
    logic [RANK_W-1:0]                   lru_rank;

    assign fire        = r_req_valid && (!r_rsp_valid || i_rsp_ready);
    assign o_req_ready = !r_req_valid || fire;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_comb begin
        cap_eff = lkvc_pkg::CAP_W'(0) == r_capacity ? CMP_W'(1) :
                  (CMP_W'(r_capacity) > CMP_W'(MAX_ENTRIES) ? CMP_W'(MAX_ENTRIES)
                                                            : CMP_W'(r_capacity));
        full     = (CMP_W'(r_fill) >= cap_eff) && (r_fill != '0);
        lru_rank = RANK_W'(r_fill - FILL_W'(1));
    end

    // parallel compare; keys of valid entries are distinct, first match wins anyway
    always_comb begin
        logic seen;
        seen      = 1'b0;
        hit_oh    = '0;
        hit_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (!seen && r_valid[i] && r_key[i] == r_req.key) begin
                seen      = 1'b1;
                hit_oh[i] = 1'b1;
                hit_rank  = r_rank[i];
                hit_value = r_value[i];
            end
        end
        hit = seen;
    end

    // victim is the valid entry holding the oldest rank; the new key then goes
    // to the lowest free slot, counting the victim's slot as free
    always_comb begin
        logic vseen;
        logic fseen;
        vseen     = 1'b0;
        fseen     = 1'b0;
        victim_oh = '0;
        slot_oh   = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (full && !vseen && r_valid[i] && r_rank[i] == lru_rank) begin
                vseen        = 1'b1;
                victim_oh[i] = 1'b1;
            end
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (!fseen && (!r_valid[i] || victim_oh[i])) begin
                fseen      = 1'b1;
                slot_oh[i] = 1'b1;
            end
        end
    end

    always_comb begin
        logic is_put;
        logic insert;
        is_put  = (r_req.op == lkvc_pkg::OP_PUT);
        insert  = is_put && !hit;
        n_valid = r_valid;
        n_fill  = r_fill;
        key_wr  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
        end

        if (hit) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (hit_oh[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && r_rank[i] < hit_rank) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end
        end else if (insert) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (slot_oh[i]) begin
                    n_valid[i] = 1'b1;
                    n_rank[i]  = '0;
                    key_wr[i]  = 1'b1;
                end else if (victim_oh[i]) begin
                    n_valid[i] = 1'b0;
                    n_rank[i]  = '0;
                end else if (r_valid[i]) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end
            // eviction and insert cancel out in the count
            if (victim_oh == '0 && slot_oh != '0) begin
                n_fill = r_fill + FILL_W'(1);
            end
        end

        n_rsp.found     = hit;
        n_rsp.evicted   = insert && (victim_oh != '0);
        n_rsp.value_out = is_put ? lkvc_pkg::VALUE_PUT
                                 : (hit ? hit_value : lkvc_pkg::VALUE_MISS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_valid     <= '0;
            r_fill      <= '0;
            r_capacity  <= lkvc_pkg::CAP_RESET;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (o_req_ready) begin
                r_req_valid <= i_req_valid;
            end
            if (fire) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
                r_valid    <= '0;
                r_fill     <= '0;
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    r_rank[i] <= '0;
                end
            end else if (fire) begin
                r_valid <= n_valid;
                r_fill  <= n_fill;
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    r_rank[i] <= n_rank[i];
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_req <= i_req;
        end
        if (fire) begin
            r_rsp <= n_rsp;
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (fire && !i_cfg_we && (key_wr[i] || hit_oh[i])
                && r_req.op == lkvc_pkg::OP_PUT) begin
                r_key[i]   <= r_req.key;
                r_value[i] <= r_req.value;
            end
        end
    end

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_fill) <= CMP_W'(MAX_ENTRIES))
        else $error("fill count above entry count");

    a_fill_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_fill))
        else $error("fill count disagrees with valid bits");

    a_evict_only_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && r_rsp.evicted) |-> !r_rsp.found)
        else $error("eviction reported on a hit");

    a_cfg_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_fill == '0 && r_valid == '0))
        else $error("capacity write did not empty the store");

endmodule

>>> sim/lru_key_value_cache_tb.sv
`timescale 1ns / 100ps
// lru_key_value_cache_tb: self-checking bench for the LRU key/value cache.
// Uses lkvc_pkg and lru_key_value_cache; a class mirrors the store and
// checks every response in order against its own prediction.
module lru_key_value_cache_tb;

    localparam int SLOTS       = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 64;
    localparam int RAND_ITEMS  = 36;
    localparam int PHASES      = 11;

    localparam logic [31:0] K_MIN = 32'h8000_0000;
    localparam logic [31:0] K_MAX = 32'h7fff_ffff;

    // Mirror of the store: predicts each response and checks it when it arrives.
    class lru_mirror;
        logic [lkvc_pkg::KEY_W-1:0]   key_tab[SLOTS];
        logic [lkvc_pkg::VALUE_W-1:0] val_tab[SLOTS];
        bit                           used[SLOTS];
        int unsigned                  age[SLOTS];
        int unsigned                  held;
        logic [lkvc_pkg::CAP_W-1:0]   cap;
        lkvc_pkg::t_rsp               expected_rsp[$];
        int                           faults;

        function new();
            faults = 0;
            set_capacity(lkvc_pkg::CAP_RESET);
        endfunction

        function void set_capacity(input logic [lkvc_pkg::CAP_W-1:0] c);
            cap  = c;
            held = 0;
            for (int i = 0; i < SLOTS; i++) begin
                used[i] = 0;
                age[i]  = 0;
            end
        endfunction

        function int unsigned limit();
            if (cap == 0) return 1;
            if (cap > SLOTS) return SLOTS;
            return cap;
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction

        // entries more recent than s age by one, s becomes the newest
        function void promote(input int s);
            int unsigned r;
            r = age[s];
            for (int i = 0; i < SLOTS; i++)
                if (used[i] && age[i] < r) age[i]++;
            age[s] = 0;
        endfunction

        function void note_request(input lkvc_pkg::t_req r);
            lkvc_pkg::t_rsp e;
            int   hit;
            hit         = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (used[i] && key_tab[i] == r.key) begin
                    hit = i;
                    break;
                end
            end
            e.found     = (hit >= 0);
            e.value_out = lkvc_pkg::VALUE_PUT;
            e.evicted   = 1'b0;
            if (r.op == lkvc_pkg::OP_GET) begin
                if (hit >= 0) begin
                    e.value_out = val_tab[hit];
                    promote(hit);
                end else begin
                    e.value_out = lkvc_pkg::VALUE_MISS;
                end
            end else if (hit >= 0) begin
                val_tab[hit] = r.value;
                promote(hit);
            end else begin
                if (held >= limit() && held > 0) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (used[i] && age[i] == held - 1) begin
                            used[i]   = 0;
                            age[i]    = 0;
                            held--;
                            e.evicted = 1'b1;
                            break;
                        end
                    end
                end
                for (int i = 0; i < SLOTS; i++) begin
                    if (!used[i]) begin
                        for (int j = 0; j < SLOTS; j++)
                            if (used[j]) age[j]++;
                        used[i]    = 1;
                        key_tab[i] = r.key;
                        val_tab[i] = r.value;
                        age[i]     = 0;
                        held++;
                        break;
                    end
                end
            end
            expected_rsp.insert(expected_rsp.size(), e);
        endfunction

        function void check_response(input lkvc_pkg::t_rsp got);
            lkvc_pkg::t_rsp e;
            if (expected_rsp.size() == 0) begin
                $error("response with nothing outstanding: found=%0b value_out=%0h evicted=%0b",
                       got.found, got.value_out, got.evicted);
                faults++;
                return;
            end
            e = expected_rsp.pop_front();
            if (got.found !== e.found) begin
                $error("found: expected %0b, actual %0b", e.found, got.found);
                faults++;
            end
            if (got.value_out !== e.value_out) begin
                $error("value_out: expected %0h, actual %0h", e.value_out, got.value_out);
                faults++;
            end
            if (got.evicted !== e.evicted) begin
                $error("evicted: expected %0b, actual %0b", e.evicted, got.evicted);
                faults++;
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       req_valid;
    logic                       req_ready;
    lkvc_pkg::t_req             req_data;
    logic                       rsp_valid;
    logic                       rsp_ready;
    lkvc_pkg::t_rsp             rsp_data;
    logic                       cfg_we;
    logic [lkvc_pkg::CAP_W-1:0] cfg_wdata;

    lru_mirror   book;
    int          burst_left;
    int          hold_requests;
    int          holds_served;
    int          cycle_count;
    logic [31:0] key_pool[$];

    lru_key_value_cache #(
        .MAX_ENTRIES(SLOTS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(req_valid),
        .o_req_ready(req_ready),
        .i_req      (req_data),
        .o_rsp_valid(rsp_valid),
        .i_rsp_ready(rsp_ready),
        .o_rsp      (rsp_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_valid && rsp_ready)
            book.check_response(rsp_data);
    end

    // Response side: changing stall pattern, plus a long hold-off on request.
    initial begin
        int mode;
        int mode_left;
        rsp_ready = 1'b1;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(negedge i_clk);
            if (holds_served < hold_requests) begin
                rsp_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                holds_served++;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    0: rsp_ready = 1'b1;
                    1: rsp_ready = 1'($urandom_range(0, 1));
                    default: rsp_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic lkvc_pkg::t_req make_req(input lkvc_pkg::t_op op,
                                                input logic [31:0] k,
                                                input logic [31:0] v);
        lkvc_pkg::t_req r;
        r.op    = op;
        r.key   = k;
        r.value = v;
        return r;
    endfunction

    // Gaps between bursts; some bursts run long with no gaps at all.
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            req_valid = 1'b0;
            req_data  = make_req(lkvc_pkg::t_op'($urandom_range(0, 1)), $urandom, $urandom);
            repeat (gap - 1) @(negedge i_clk);
            if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(20, 40);
            else                           burst_left = $urandom_range(1, 10);
        end
    endtask

    task automatic send_item(input lkvc_pkg::t_req r);
        @(negedge i_clk);
        req_valid = 1'b1;
        req_data  = r;
        @(posedge i_clk);
        while (!req_ready) @(posedge i_clk);
        book.note_request(r);
        pace();
    endtask

    task automatic send(input lkvc_pkg::t_op op, input logic [31:0] k,
                        input logic [31:0] v);
        send_item(make_req(op, k, v));
    endtask

    // Capacity writes only once the store is idle; each write empties it.
    task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] c);
        @(negedge i_clk);
        req_valid = 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_wdata = c;
        @(negedge i_clk);
        cfg_we    = 1'b0;
        book.set_capacity(c);
        burst_left = 0;
    endtask

    // Mostly keys from a pool a little larger than capacity, so hits and
    // evictions both happen; the rest are fresh random keys.
    task automatic send_random_phase(input int count);
        int unsigned pool_n;
        logic [31:0] k;
        key_pool.delete();
        pool_n = book.limit() + $urandom_range(1, 4);
        repeat (pool_n) key_pool.insert(key_pool.size(), $urandom);
        repeat (count) begin
            if ($urandom_range(0, 6) == 0) k = $urandom;
            else                           k = key_pool[$urandom_range(0, pool_n - 1)];
            send(lkvc_pkg::t_op'($urandom_range(0, 1)), k, $urandom);
        end
    endtask

    initial begin
        logic [lkvc_pkg::CAP_W-1:0] cap_plan[PHASES];
        book          = new();
        burst_left    = 0;
        hold_requests = 0;
        holds_served  = 0;
        cycle_count   = 0;
        i_rst_n       = 1'b0;
        req_valid     = 1'b0;
        req_data      = make_req(lkvc_pkg::OP_GET, '0, '0);
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        cap_plan      = '{5'd16, 5'd2, 5'd0, 5'd31, 5'd1, 5'd17, 5'd16, 5'd3, 5'd7,
                          5'd0, 5'd0};
        cap_plan[9]   = lkvc_pkg::CAP_W'($urandom_range(0, 31));
        cap_plan[10]  = lkvc_pkg::CAP_W'($urandom_range(0, 31));
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset capacity: extreme keys and values, hits, misses, update
        send(lkvc_pkg::OP_GET, K_MIN, 32'hffff_ffff);
        send(lkvc_pkg::OP_PUT, K_MIN, 32'h8000_0000);
        send(lkvc_pkg::OP_PUT, K_MAX, 32'h7fff_ffff);
        send(lkvc_pkg::OP_PUT, 32'h0, 32'h0);
        send(lkvc_pkg::OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
        send(lkvc_pkg::OP_GET, K_MIN, 32'h0);
        send(lkvc_pkg::OP_GET, K_MAX, 32'h1234_5678);
        send(lkvc_pkg::OP_GET, 32'h0, 32'hffff_ffff);
        send(lkvc_pkg::OP_GET, 32'hffff_ffff, 32'h0);
        send(lkvc_pkg::OP_PUT, K_MIN, 32'h5555_5555);
        send(lkvc_pkg::OP_GET, K_MIN, 32'haaaa_aaaa);
        send(lkvc_pkg::OP_GET, 32'h1, 32'h0);
        send_random_phase(RAND_ITEMS);

        for (int p = 1; p < PHASES; p++) begin
            write_capacity(cap_plan[p]);
            if (cap_plan[p] == 5'd2) begin
                // eviction picks the least recent; update on a full store keeps all
                send(lkvc_pkg::OP_PUT, 32'ha, 32'h1);
                send(lkvc_pkg::OP_PUT, 32'hb, 32'h2);
                send(lkvc_pkg::OP_GET, 32'ha, 32'h0);
                send(lkvc_pkg::OP_PUT, 32'hc, 32'h3);
                send(lkvc_pkg::OP_GET, 32'hb, 32'h0);
                send(lkvc_pkg::OP_PUT, 32'ha, 32'h4);
                send(lkvc_pkg::OP_GET, 32'hc, 32'h0);
            end else if (cap_plan[p] == 5'd0 && p == 2) begin
                // zero capacity acts as one entry
                send(lkvc_pkg::OP_PUT, 32'ha, 32'h1);
                send(lkvc_pkg::OP_PUT, 32'hb, 32'h2);
                send(lkvc_pkg::OP_GET, 32'ha, 32'h0);
                send(lkvc_pkg::OP_GET, 32'hb, 32'h0);
            end
            if (p == 1 || p == 6) hold_requests++;
            send_random_phase(RAND_ITEMS);
        end

        @(negedge i_clk);
        req_valid = 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (book.faults == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
